### rtl/core/bcr_pkg.sv
// shared types and constants of the bicubic resampling weight generator
package bcr_pkg;

   localparam int MAX_TAPS = 4;
   localparam int SLOT_W   = 2;
   localparam int CNT_W    = 3;

   localparam int IDX_W    = 16;
   localparam int LEN_W    = 16;
   localparam int SCL_W    = 24;
   localparam int CSR_W    = 24;
   localparam int CSR_IDX_W = 3;

   localparam int CTR_W    = 41;
   localparam int BND_W    = 45;
   localparam int XMIN_W   = 28;
   localparam int DIST_W   = 27;
   localparam int DVD_W    = 43;
   localparam int QUO_W    = 17;
   localparam int U_W      = 17;
   localparam int POLY_W   = 58;
   localparam int WGT_W    = 18;
   localparam int SUM_W    = 21;
   localparam int OUTW_W   = 16;
   localparam int PEAK_W   = 15;

   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_LENGTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_FACTOR = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SUPPORT_WIDTH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ANTIALIAS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ALIGN_HALF = 3'd4;

   typedef struct packed {
      logic [LEN_W-1:0] input_length;
      logic [SCL_W-1:0] scale_factor;
      logic [SCL_W-1:0] support_width;
      logic             antialias_enable;
      logic             align_corners_half;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CENTER, ST_BOUND, ST_WIN, ST_DIST, ST_UPREP, ST_UGO, ST_UDIV,
      ST_SQ, ST_CUBE, ST_POLY, ST_NPREP, ST_NGO, ST_NDIV, ST_NSTORE, ST_OUT
   } state_type;

   typedef struct packed {
      logic load_item;
      logic calc_center;
      logic calc_bound;
      logic calc_win;
      logic calc_dist;
      logic calc_uprep;
      logic div_start;
      logic div_norm;
      logic load_uq;
      logic calc_sq;
      logic calc_cube;
      logic calc_poly;
      logic calc_nprep;
      logic store_norm;
      logic k_clr;
      logic k_inc;
   } cmd_type;

   typedef struct packed {
      logic cnt_zero;
      logic k_last;
      logic slot_last;
      logic need_udiv;
      logic need_ndiv;
      logic div_done;
   } sts_type;

endpackage

### rtl/core/bcr_channels.sv
// request and response channel interfaces
interface bcr_req_if;
   logic                     valid;
   logic                     ready;
   logic [bcr_pkg::IDX_W-1:0] out_index;
   modport source (output valid, output out_index, input ready);
   modport sink (input valid, input out_index, output ready);
endinterface

interface bcr_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [15:0]                       first_input;
   logic [bcr_pkg::CNT_W-1:0]         tap_count;
   logic [bcr_pkg::SLOT_W-1:0]        tap_slot;
   logic signed [bcr_pkg::OUTW_W-1:0] tap_weight;
   logic [bcr_pkg::PEAK_W-1:0]        peak_weight;
   logic                              last_tap;
   modport source (output valid, output first_input, output tap_count, output tap_slot,
                   output tap_weight, output peak_weight, output last_tap, input ready);
   modport sink (input valid, input first_input, input tap_count, input tap_slot,
                 input tap_weight, input peak_weight, input last_tap, output ready);
endinterface

### rtl/core/bcr_div.sv
// restoring divider, one quotient bit per cycle
module bcr_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [bcr_pkg::DVD_W-1:0]   dividend,
   input  logic [bcr_pkg::SCL_W-1:0]   divisor,
   output logic                        done,
   output logic [bcr_pkg::QUO_W-1:0]   quotient
);
   localparam int CW = $clog2(bcr_pkg::QUO_W + 1);

   logic [bcr_pkg::DVD_W-1:0] rem_ff, rem_in, dsh_ff, dsh_in;
   logic [bcr_pkg::QUO_W-1:0] q_ff, q_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic                      busy_ff, busy_in, done_ff, done_in;
   logic                      ge;

   assign ge = rem_ff >= dsh_ff;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         dsh_in  = bcr_pkg::DVD_W'({divisor, {(bcr_pkg::QUO_W-1){1'b0}}});
         q_in    = '0;
         cnt_in  = CW'(bcr_pkg::QUO_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? rem_ff - dsh_ff : rem_ff;
         q_in   = {q_ff[bcr_pkg::QUO_W-2:0], ge};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;
endmodule

### rtl/core/bcr_ctrl.sv
// sequencing state machine
module bcr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             rsp_ready,
   input  bcr_pkg::sts_type sts,
   output logic             req_ready,
   output logic             rsp_valid,
   output bcr_pkg::cmd_type cmd
);
   bcr_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bcr_pkg::ST_IDLE:   if (req_valid) state_in = bcr_pkg::ST_CENTER;
         bcr_pkg::ST_CENTER: state_in = bcr_pkg::ST_BOUND;
         bcr_pkg::ST_BOUND:  state_in = bcr_pkg::ST_WIN;
         bcr_pkg::ST_WIN:    state_in = bcr_pkg::ST_DIST;
         bcr_pkg::ST_DIST:   state_in = sts.cnt_zero ? bcr_pkg::ST_OUT : bcr_pkg::ST_UPREP;
         bcr_pkg::ST_UPREP:  state_in = sts.need_udiv ? bcr_pkg::ST_UGO : bcr_pkg::ST_SQ;
         bcr_pkg::ST_UGO:    state_in = bcr_pkg::ST_UDIV;
         bcr_pkg::ST_UDIV:   if (sts.div_done) state_in = bcr_pkg::ST_SQ;
         bcr_pkg::ST_SQ:     state_in = bcr_pkg::ST_CUBE;
         bcr_pkg::ST_CUBE:   state_in = bcr_pkg::ST_POLY;
         bcr_pkg::ST_POLY:   state_in = sts.k_last ? bcr_pkg::ST_NPREP : bcr_pkg::ST_DIST;
         bcr_pkg::ST_NPREP:  state_in = sts.need_ndiv ? bcr_pkg::ST_NGO : bcr_pkg::ST_NSTORE;
         bcr_pkg::ST_NGO:    state_in = bcr_pkg::ST_NDIV;
         bcr_pkg::ST_NDIV:   if (sts.div_done) state_in = bcr_pkg::ST_NSTORE;
         bcr_pkg::ST_NSTORE: state_in = sts.k_last ? bcr_pkg::ST_OUT : bcr_pkg::ST_NPREP;
         bcr_pkg::ST_OUT:    if (rsp_ready && sts.slot_last) state_in = bcr_pkg::ST_IDLE;
         default:            state_in = bcr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         bcr_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         bcr_pkg::ST_CENTER: cmd.calc_center = 1'b1;
         bcr_pkg::ST_BOUND:  cmd.calc_bound = 1'b1;
         bcr_pkg::ST_WIN: begin
            cmd.calc_win = 1'b1;
            cmd.k_clr    = 1'b1;
         end
         bcr_pkg::ST_DIST:   cmd.calc_dist = 1'b1;
         bcr_pkg::ST_UPREP:  cmd.calc_uprep = 1'b1;
         bcr_pkg::ST_UGO:    cmd.div_start = 1'b1;
         bcr_pkg::ST_UDIV:   cmd.load_uq = sts.div_done;
         bcr_pkg::ST_SQ:     cmd.calc_sq = 1'b1;
         bcr_pkg::ST_CUBE:   cmd.calc_cube = 1'b1;
         bcr_pkg::ST_POLY: begin
            cmd.calc_poly = 1'b1;
            cmd.k_clr     = sts.k_last;
            cmd.k_inc     = !sts.k_last;
         end
         bcr_pkg::ST_NPREP:  cmd.calc_nprep = 1'b1;
         bcr_pkg::ST_NGO: begin
            cmd.div_start = 1'b1;
            cmd.div_norm  = 1'b1;
         end
         bcr_pkg::ST_NDIV:   cmd.div_norm = 1'b1;
         bcr_pkg::ST_NSTORE: begin
            cmd.store_norm = 1'b1;
            cmd.k_clr      = sts.k_last;
            cmd.k_inc      = !sts.k_last;
         end
         bcr_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            cmd.k_inc = rsp_ready && !sts.slot_last;
            cmd.k_clr = rsp_ready && sts.slot_last;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bcr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

### rtl/core/bcr_dp.sv
// window, kernel and normalization datapath
module bcr_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  bcr_pkg::cfg_type                    cfg,
   input  bcr_pkg::cmd_type                    cmd,
   input  logic [bcr_pkg::IDX_W-1:0]           out_index,
   output bcr_pkg::sts_type                    sts,
   output logic [15:0]                         first_input,
   output logic [bcr_pkg::CNT_W-1:0]           tap_count,
   output logic [bcr_pkg::SLOT_W-1:0]          tap_slot,
   output logic signed [bcr_pkg::OUTW_W-1:0]   tap_weight,
   output logic [bcr_pkg::PEAK_W-1:0]          peak_weight,
   output logic                                last_tap
);
   localparam int BW = bcr_pkg::BND_W;
   localparam int PW = bcr_pkg::POLY_W;
   localparam int WW = bcr_pkg::WGT_W;
   localparam int SW = bcr_pkg::SUM_W;
   localparam int NW = 32;

   logic [bcr_pkg::IDX_W-1:0]   idx_ff;
   logic [bcr_pkg::CTR_W-1:0]   center_ff;
   logic signed [BW-1:0]        lo_ff, hi_ff;
   logic [bcr_pkg::XMIN_W-1:0]  xmin_ff;
   logic [bcr_pkg::CNT_W-1:0]   cnt_ff;
   logic [bcr_pkg::SLOT_W-1:0]  k_ff;
   logic [bcr_pkg::DIST_W-1:0]  a_ff;
   logic [bcr_pkg::DVD_W-1:0]   udvd_ff, nd_ff;
   logic [bcr_pkg::U_W-1:0]     u_ff;
   logic                        far_ff;
   logic [2*bcr_pkg::U_W-1:0]   u2_ff;
   logic [3*bcr_pkg::U_W-1:0]   u3_ff;
   logic signed [WW-1:0]        warr_ff [bcr_pkg::MAX_TAPS];
   logic signed [bcr_pkg::OUTW_W-1:0] qarr_ff [bcr_pkg::MAX_TAPS];
   logic signed [SW-1:0]        sum_ff;
   logic [bcr_pkg::SCL_W-1:0]   ad_ff;
   logic                        sat_ff, neg_ff, zsum_ff;
   logic signed [bcr_pkg::OUTW_W-1:0] zq_ff;
   logic [bcr_pkg::PEAK_W-1:0]  peak_ff;

   logic                        div_done;
   logic [bcr_pkg::QUO_W-1:0]   div_q;
   logic [bcr_pkg::DVD_W-1:0]   div_dvd;
   logic [bcr_pkg::SCL_W-1:0]   div_dvs;

   // window bounds
   logic [bcr_pkg::U_W-1:0]     h;
   logic signed [BW-1:0]        ctr_s, sup2_s, off_s, lo_c, hi_c;
   logic [bcr_pkg::XMIN_W-1:0]  xmin_c, xmax_raw, xmax_c;
   logic signed [bcr_pkg::XMIN_W:0] diff_c;
   logic [bcr_pkg::CNT_W-1:0]   cnt_c;

   assign h      = {idx_ff, ~cfg.align_corners_half};
   assign ctr_s  = BW'($signed({1'b0, center_ff}));
   assign sup2_s = BW'($signed({1'b0, cfg.support_width, 1'b0}));
   assign off_s  = cfg.align_corners_half ? BW'(131072) : BW'(65536);
   assign lo_c   = ctr_s - sup2_s + off_s;
   assign hi_c   = ctr_s + sup2_s + off_s;

   assign xmin_c   = lo_ff[BW-1] ? '0 : lo_ff[BW-1:17];
   assign xmax_raw = hi_ff[BW-1:17];
   assign xmax_c   = (xmax_raw > bcr_pkg::XMIN_W'(cfg.input_length))
                     ? bcr_pkg::XMIN_W'(cfg.input_length) : xmax_raw;
   assign diff_c   = $signed({1'b0, xmax_c}) - $signed({1'b0, xmin_c});
   always_comb begin
      if (diff_c <= 0) begin
         cnt_c = '0;
      end else if (diff_c >= (bcr_pkg::XMIN_W+1)'(bcr_pkg::MAX_TAPS)) begin
         cnt_c = bcr_pkg::CNT_W'(bcr_pkg::MAX_TAPS);
      end else begin
         cnt_c = diff_c[bcr_pkg::CNT_W-1:0];
      end
   end

   // tap distance
   localparam int PSW = BW + 2;
   logic [bcr_pkg::XMIN_W:0]    xk;
   logic signed [PSW-1:0]       pos_c, apos_c;
   assign xk     = {1'b0, xmin_ff} + (bcr_pkg::XMIN_W+1)'(k_ff);
   assign pos_c  = $signed({1'b0, xk, 17'b0}) - PSW'($signed({1'b0, center_ff}))
                   + (cfg.align_corners_half ? PSW'(0) : PSW'(65536));
   assign apos_c = pos_c[PSW-1] ? -pos_c : pos_c;

   // kernel argument
   logic                        aa_on;
   logic [bcr_pkg::DVD_W-1:0]   udvd_c;
   logic                        far_aa;
   logic [bcr_pkg::DIST_W-1:0]  ua_c;
   assign aa_on  = cfg.antialias_enable && (cfg.scale_factor[bcr_pkg::SCL_W-1:16] != '0);
   assign udvd_c = {1'b0, a_ff, 15'b0} + bcr_pkg::DVD_W'(cfg.scale_factor >> 1);
   assign far_aa = udvd_c >= bcr_pkg::DVD_W'({cfg.scale_factor, 17'b0});
   assign ua_c   = bcr_pkg::DIST_W'(({1'b0, a_ff} + 28'd1) >> 1);

   // cubic polynomial
   logic signed [PW-1:0]        t1, t2, t3, c4, v_c, r_c;
   logic signed [WW-1:0]        w_c;
   assign t1  = PW'($signed({1'b0, u3_ff}));
   assign t2  = PW'($signed({1'b0, u2_ff, 16'b0}));
   assign t3  = PW'($signed({1'b0, u_ff, 32'b0}));
   assign c4  = PW'(64'sd1 <<< 50);
   assign v_c = !u_ff[bcr_pkg::U_W-1] ? (PW'(5) * t1 - PW'(9) * t2 + c4)
                                      : (PW'(-3) * (t1 - PW'(5) * t2 + PW'(8) * t3 - c4));
   assign r_c = (v_c + PW'(64'sd1 <<< 33)) >>> 34;
   assign w_c = far_ff ? '0 : r_c[WW-1:0];

   // normalization prep
   logic signed [WW-1:0]        wk;
   logic signed [NW-1:0]        num_c;
   logic [NW-1:0]               an_c;
   logic [SW-1:0]               ad_c;
   logic [bcr_pkg::DVD_W-1:0]   nd_c;
   logic                        sat_c, zsum_c;
   logic signed [WW-1:0]        zr_c;
   logic signed [bcr_pkg::OUTW_W-1:0] zq_c;
   assign wk     = warr_ff[k_ff];
   assign num_c  = NW'(wk) <<< 14;
   assign an_c   = num_c[NW-1] ? NW'(-num_c) : NW'(num_c);
   assign ad_c   = sum_ff[SW-1] ? SW'(-sum_ff) : SW'(sum_ff);
   assign nd_c   = bcr_pkg::DVD_W'(an_c) + bcr_pkg::DVD_W'(ad_c >> 1);
   assign sat_c  = nd_c >= bcr_pkg::DVD_W'({ad_c, 15'b0});
   assign zsum_c = sum_ff == '0;
   assign zr_c   = (wk + WW'(2)) >>> 2;
   assign zq_c   = (zr_c > WW'(32767)) ? 16'sd32767
                 : (zr_c < -WW'(32768)) ? -16'sd32768 : zr_c[bcr_pkg::OUTW_W-1:0];

   // normalized weight
   logic [bcr_pkg::OUTW_W-1:0]        mag_c;
   logic signed [bcr_pkg::OUTW_W-1:0] q_c;
   assign mag_c = bcr_pkg::OUTW_W'(div_q);
   always_comb begin
      if (zsum_ff) begin
         q_c = zq_ff;
      end else if (sat_ff) begin
         q_c = neg_ff ? -16'sd32768 : 16'sd32767;
      end else begin
         q_c = neg_ff ? -$signed(mag_c) : $signed(mag_c);
      end
   end

   assign div_dvd = cmd.div_norm ? nd_ff : udvd_ff;
   assign div_dvs = cmd.div_norm ? ad_ff : cfg.scale_factor;

   bcr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
      end else if (cmd.k_clr) begin
         k_ff <= '0;
      end else if (cmd.k_inc) begin
         k_ff <= k_ff + bcr_pkg::SLOT_W'(1);
      end
      if (cmd.load_item) idx_ff <= out_index;
      if (cmd.calc_center) center_ff <= cfg.scale_factor * h;
      if (cmd.calc_bound) begin
         lo_ff <= lo_c;
         hi_ff <= hi_c;
      end
      if (cmd.calc_win) begin
         xmin_ff <= xmin_c;
         cnt_ff  <= cnt_c;
         sum_ff  <= '0;
         peak_ff <= '0;
      end
      if (cmd.calc_dist) a_ff <= apos_c[bcr_pkg::DIST_W-1:0];
      if (cmd.calc_uprep) begin
         udvd_ff <= udvd_c;
         u_ff    <= ua_c[bcr_pkg::U_W-1:0];
         far_ff  <= aa_on ? far_aa : (ua_c[bcr_pkg::DIST_W-1:bcr_pkg::U_W] != '0);
      end
      if (cmd.load_uq) u_ff <= div_q;
      if (cmd.calc_sq) u2_ff <= u_ff * u_ff;
      if (cmd.calc_cube) u3_ff <= u2_ff * u_ff;
      if (cmd.calc_poly) begin
         warr_ff[k_ff] <= w_c;
         sum_ff        <= sum_ff + SW'(w_c);
      end
      if (cmd.calc_nprep) begin
         nd_ff   <= nd_c;
         ad_ff   <= bcr_pkg::SCL_W'(ad_c);
         sat_ff  <= sat_c;
         zsum_ff <= zsum_c;
         neg_ff  <= wk[WW-1] != sum_ff[SW-1];
         zq_ff   <= zq_c;
      end
      if (cmd.store_norm) begin
         qarr_ff[k_ff] <= q_c;
         if (!zsum_ff && !q_c[bcr_pkg::OUTW_W-1] && (q_c[bcr_pkg::PEAK_W-1:0] > peak_ff)) begin
            peak_ff <= q_c[bcr_pkg::PEAK_W-1:0];
         end
      end
   end

   assign sts.cnt_zero  = cnt_ff == '0;
   assign sts.k_last    = {1'b0, k_ff} == cnt_ff - bcr_pkg::CNT_W'(1);
   assign sts.slot_last = k_ff == bcr_pkg::SLOT_W'(bcr_pkg::MAX_TAPS - 1);
   assign sts.need_udiv = aa_on && !far_aa;
   assign sts.need_ndiv = !zsum_c && !sat_c;
   assign sts.div_done  = div_done;

   assign first_input = (xmin_ff[bcr_pkg::XMIN_W-1:16] != '0) ? 16'hFFFF : xmin_ff[15:0];
   assign tap_count   = cnt_ff;
   assign tap_slot    = k_ff;
   assign tap_weight  = ({1'b0, k_ff} < cnt_ff) ? qarr_ff[k_ff] : '0;
   assign peak_weight = peak_ff;
   assign last_tap    = sts.slot_last;
endmodule

### rtl/core/bicubic_resample_weight_gen.sv
// top level of the bicubic resampling weight generator
// each transaction computes the window bounds, the weight of each tap, then the normalized
//   weights, with a bit-serial division for each tap inside the kernel span with antialias
//   active and for each tap with a nonzero sum whose weight does not saturate; then 4 results
// throughput: one transaction at a time, the next is taken after the fourth result
// reset: synchronous, returns the controller to idle and the configuration to its defaults
module bicubic_resample_weight_gen (
   input  logic                            clock,
   input  logic                            reset,
   bcr_req_if.sink                         req_ch,
   bcr_rsp_if.source                       rsp_ch,
   input  logic                            csr_write_enable,
   input  logic [bcr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bcr_pkg::CSR_W-1:0]       csr_write_data
);
   bcr_pkg::cfg_type cfg_ff, cfg_in;
   bcr_pkg::cmd_type cmd;
   bcr_pkg::sts_type sts;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            bcr_pkg::CSR_INPUT_LENGTH:  cfg_in.input_length = csr_write_data[15:0];
            bcr_pkg::CSR_SCALE_FACTOR:  cfg_in.scale_factor = csr_write_data;
            bcr_pkg::CSR_SUPPORT_WIDTH: cfg_in.support_width = csr_write_data;
            bcr_pkg::CSR_ANTIALIAS:     cfg_in.antialias_enable = csr_write_data[0];
            bcr_pkg::CSR_ALIGN_HALF:    cfg_in.align_corners_half = csr_write_data[0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.input_length       <= 16'd8;
         cfg_ff.scale_factor       <= 24'd65536;
         cfg_ff.support_width      <= 24'd131072;
         cfg_ff.antialias_enable   <= 1'b0;
         cfg_ff.align_corners_half <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .cmd       (cmd)
   );

   bcr_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .cmd         (cmd),
      .out_index   (req_ch.out_index),
      .sts         (sts),
      .first_input (rsp_ch.first_input),
      .tap_count   (rsp_ch.tap_count),
      .tap_slot    (rsp_ch.tap_slot),
      .tap_weight  (rsp_ch.tap_weight),
      .peak_weight (rsp_ch.peak_weight),
      .last_tap    (rsp_ch.last_tap)
   );
endmodule

### rtl/core/bcr_checker.sv
// port-level checks of the weight generator
module bcr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  tap_count,
   input logic [1:0]  tap_slot,
   input logic [15:0] tap_weight,
   input logic [14:0] peak_weight,
   input logic        last_tap
);
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while results pending");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(tap_slot) && $stable(tap_weight))
      else $error("stalled response changed");

   a_last_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (last_tap == (tap_slot == 2'd3))) else $error("last mark misplaced");

   a_zero_past_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ({1'b0, tap_slot} >= tap_count) |-> tap_weight == 16'd0)
      else $error("weight beyond tap count");

   a_empty_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && tap_count == 3'd0 |-> peak_weight == 15'd0)
      else $error("peak on empty window");
endmodule

bind bicubic_resample_weight_gen bcr_checker u_bcr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .tap_count   (rsp_ch.tap_count),
   .tap_slot    (rsp_ch.tap_slot),
   .tap_weight  (rsp_ch.tap_weight),
   .peak_weight (rsp_ch.peak_weight),
   .last_tap    (rsp_ch.last_tap)
);

### dv/bcr_tb_if.sv
`timescale 1ns / 1ps
// expected-result type shared by the testbench files
package bcr_tb_pkg;
   typedef struct packed {
      logic [15:0]        first_input;
      logic [2:0]         tap_count;
      logic [1:0]         tap_slot;
      logic signed [15:0] tap_weight;
      logic [14:0]        peak_weight;
      logic               last_tap;
   } tap_result_type;
endpackage

### dv/bcr_checker.sv
`timescale 1ns / 1ps
// scoreboard: predicts resampling taps for each request transaction and compares responses
module bcr_scoreboard (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [15:0] req_out_index,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  bcr_tb_pkg::tap_result_type rsp_data,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_write_data,
   output int          fail_count,
   output int          pending
);
   logic [15:0] len_q;
   logic [23:0] scale_q, support_q;
   logic        aa_q, align_q;
   bcr_tb_pkg::tap_result_type taps_expected[$];

   function automatic longint rnd_shift(longint v, int s);
      longint h;
      h = longint'(1) << (s - 1);
      if (v >= 0) return (v + h) >>> s;
      return -(((-v) + h - 1) >>> s);
   endfunction

   function automatic longint cubic_weight(longint u);
      longint one, u2, u3, v;
      one = longint'(1) << 16;
      if (u >= 2 * one) return 0;
      u2 = u * u;
      u3 = u2 * u;
      if (u < one) v = 5 * u3 - 9 * u2 * one + (longint'(4) << 48);
      else v = -3 * (u3 - 5 * u2 * one + 8 * u * (longint'(1) << 32) - (longint'(4) << 48));
      return rnd_shift(v, 34);
   endfunction

   task automatic predict_taps(input logic [15:0] idx);
      longint scl, sup2, half17, dlt, hh, center, lo, hi, xmin, xmax, cnt, sum, peak;
      longint pos, a, u, num, an, ad, mq, q;
      longint w[4];
      bit aa;
      bcr_tb_pkg::tap_result_type r;
      scl = longint'(scale_q);
      sup2 = longint'(support_q) * 2;
      half17 = longint'(1) << 16;
      dlt = align_q ? half17 : 0;
      hh = 2 * longint'(idx) + (align_q ? 0 : 1);
      center = scl * hh;
      lo = center - sup2 + half17 + dlt;
      hi = center + sup2 + half17 + dlt;
      xmin = lo < 0 ? 0 : (lo >>> 17);
      xmax = hi >>> 17;
      aa = aa_q && scl >= 65536;
      sum = 0;
      peak = 0;
      if (xmax > longint'(len_q)) xmax = longint'(len_q);
      cnt = xmax - xmin;
      if (cnt < 0) cnt = 0;
      if (cnt > bcr_pkg::MAX_TAPS) cnt = bcr_pkg::MAX_TAPS;
      for (int k = 0; k < 4; k++) begin
         w[k] = 0;
         if (k < cnt) begin
            pos = ((xmin + k) <<< 17) - center + (half17 - dlt);
            a = pos < 0 ? -pos : pos;
            if (aa) u = ((a <<< 15) + (scl >>> 1)) / scl;
            else u = (a + 1) >>> 1;
            w[k] = cubic_weight(u);
            sum += w[k];
         end
      end
      for (int k = 0; k < 4; k++) begin
         q = 0;
         if (k < cnt) begin
            if (sum != 0) begin
               num = w[k] * 16384;
               an = num < 0 ? -num : num;
               ad = sum < 0 ? -sum : sum;
               mq = (an + (ad >>> 1)) / ad;
               if (mq > 65536) mq = 65536;
               q = ((num < 0) != (sum < 0)) ? -mq : mq;
               if (q > 32767) q = 32767;
               if (q < -32768) q = -32768;
               if (q > peak) peak = q;
            end else begin
               q = rnd_shift(w[k], 2);
               if (q > 32767) q = 32767;
               if (q < -32768) q = -32768;
            end
         end
         w[k] = q;
      end
      for (int k = 0; k < 4; k++) begin
         r.first_input = xmin > 65535 ? 16'hFFFF : 16'(xmin);
         r.tap_count = 3'(cnt);
         r.tap_slot = 2'(k);
         r.tap_weight = 16'(w[k]);
         r.peak_weight = 15'(peak);
         r.last_tap = (k == bcr_pkg::MAX_TAPS - 1);
         taps_expected.push_back(r);
      end
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      bcr_tb_pkg::tap_result_type e;
      if (reset) begin
         len_q <= 16'd8;
         scale_q <= 24'd65536;
         support_q <= 24'd131072;
         aa_q <= 1'b0;
         align_q <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               bcr_pkg::CSR_INPUT_LENGTH: len_q <= csr_write_data[15:0];
               bcr_pkg::CSR_SCALE_FACTOR: scale_q <= csr_write_data;
               bcr_pkg::CSR_SUPPORT_WIDTH: support_q <= csr_write_data;
               bcr_pkg::CSR_ANTIALIAS: aa_q <= csr_write_data[0];
               bcr_pkg::CSR_ALIGN_HALF: align_q <= csr_write_data[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict_taps(req_out_index);
         if (rsp_valid && rsp_ready) begin
            if (taps_expected.size() == 0) begin
               report_mismatch("unexpected transaction slot", rsp_data.tap_slot, -1);
            end else begin
               e = taps_expected.pop_front();
               if (rsp_data.first_input !== e.first_input)
                  report_mismatch("first_input", rsp_data.first_input, e.first_input);
               if (rsp_data.tap_count !== e.tap_count)
                  report_mismatch("tap_count", rsp_data.tap_count, e.tap_count);
               if (rsp_data.tap_slot !== e.tap_slot)
                  report_mismatch("tap_slot", rsp_data.tap_slot, e.tap_slot);
               if (rsp_data.tap_weight !== e.tap_weight)
                  report_mismatch("tap_weight", rsp_data.tap_weight, e.tap_weight);
               if (rsp_data.peak_weight !== e.peak_weight)
                  report_mismatch("peak_weight", rsp_data.peak_weight, e.peak_weight);
               if (rsp_data.last_tap !== e.last_tap)
                  report_mismatch("last_tap", rsp_data.last_tap, e.last_tap);
            end
         end
      end
      pending <= taps_expected.size();
   end
endmodule

### dv/tb_bicubic_resample_weight_gen.sv
`timescale 1ns / 1ps
// testbench top: clock, reset, register phases, request stimulus and verdict
module tb_bicubic_resample_weight_gen;
   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [2:0]  csr_index;
   logic [23:0] csr_write_data;
   int          fail_count, pending, cycle_count;
   bit          calm;
   bcr_tb_pkg::tap_result_type rsp_data;

   bcr_req_if req_ch();
   bcr_rsp_if rsp_ch();

   bicubic_resample_weight_gen dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   assign rsp_data = '{rsp_ch.first_input, rsp_ch.tap_count, rsp_ch.tap_slot,
                       rsp_ch.tap_weight, rsp_ch.peak_weight, rsp_ch.last_tap};

   bcr_scoreboard u_scoreboard (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_out_index(req_ch.out_index),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data), .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 400000) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // response back-pressure
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 27);
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [23:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
   endtask

   task automatic drain_taps();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic send_index(input logic [15:0] idx);
      while (!calm && $urandom_range(99) < 27) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.out_index <= idx;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic apply_setup(input logic [15:0] len, input logic [23:0] scl,
                              input logic [23:0] sup, input logic aa, input logic al);
      drain_taps();
      csr_write(bcr_pkg::CSR_INPUT_LENGTH, 24'(len));
      csr_write(bcr_pkg::CSR_SCALE_FACTOR, scl);
      csr_write(bcr_pkg::CSR_SUPPORT_WIDTH, sup);
      csr_write(bcr_pkg::CSR_ANTIALIAS, 24'(aa));
      csr_write(bcr_pkg::CSR_ALIGN_HALF, 24'(al));
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [15:0] pick_index(input logic [15:0] len, input logic [23:0] scl);
      int span;
      if ($urandom_range(9) == 0) return 16'($urandom);
      span = int'((longint'(len) * 65536) / (scl == 0 ? 1 : scl));
      if (span > 65535) span = 65535;
      return 16'($urandom_range(span + 1));
   endfunction

   initial begin
      logic [15:0] len;
      logic [23:0] scl, sup;
      reset = 1'b1;
      calm = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_ch.valid = 1'b0;
      req_ch.out_index = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: defaults, edge indexes
      send_index(16'd0);
      send_index(16'd3);
      send_index(16'd7);
      send_index(16'd8);
      send_index(16'hFFFF);
      // antialias downscale and align
      apply_setup(16'd64, 24'd196608, 24'd65536, 1'b1, 1'b1);
      send_index(16'd0);
      send_index(16'd10);
      send_index(16'd21);
      // wide window, upscale with antialias enabled but inactive
      apply_setup(16'd100, 24'd32768, 24'd262144, 1'b1, 1'b0);
      send_index(16'd0);
      send_index(16'd50);
      send_index(16'd199);
      // zero scale, zero support, minimum length
      apply_setup(16'd1, 24'd0, 24'd0, 1'b1, 1'b1);
      send_index(16'd0);
      send_index(16'hFFFF);
      // extremes: large scale saturates first_input, zero-sum kernel region
      apply_setup(16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b0);
      send_index(16'd0);
      send_index(16'd1);
      send_index(16'hFFFF);
      apply_setup(16'hFFFF, 24'hFFFFFF, 24'd65536, 1'b0, 1'b1);
      send_index(16'd5);
      send_index(16'hAAAA);
      apply_setup(16'd20, 24'd65536, 24'd32768, 1'b0, 1'b0);
      send_index(16'd4);
      send_index(16'd19);
      send_index(16'h5555);

      // random phases
      for (int ph = 0; ph < 10; ph++) begin
         len = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 300));
         case ($urandom_range(3))
            0: scl = 24'($urandom);
            1: scl = 24'($urandom_range(16384, 65536));
            default: scl = 24'($urandom_range(65536, 327680));
         endcase
         sup = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 200000));
         apply_setup(len, scl, sup, 1'($urandom), 1'($urandom));
         calm = (ph == 4);
         for (int n = 0; n < 21; n++) send_index(pick_index(len, scl));
         calm = 1'b0;
         if (ph == 6) drain_taps();
      end

      drain_taps();
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

### files.f
rtl/core/bcr_pkg.sv
rtl/core/bcr_channels.sv
rtl/core/bcr_div.sv
rtl/core/bcr_ctrl.sv
rtl/core/bcr_dp.sv
rtl/core/bicubic_resample_weight_gen.sv
rtl/core/bcr_checker.sv
dv/bcr_tb_if.sv
dv/bcr_checker.sv
dv/tb_bicubic_resample_weight_gen.sv
